// ===== rtl/key_value_config_tokenizer_assert.svh =====
// Assertion macros for the tokenizer checker.
`ifndef KEY_VALUE_CONFIG_TOKENIZER_ASSERT_SVH
`define KEY_VALUE_CONFIG_TOKENIZER_ASSERT_SVH

// Same-cycle implication, sampled on clk and switched off during rst.
`define KVCT_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off during rst.
`define KVCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/kvct_pkg.sv =====
// Shared types and constants of the key/value config tokenizer.
`default_nettype none

package kvct_pkg;

  localparam int INDEX_W = 10;
  localparam int FIELD_W = 16;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    KIND_RECORD   = 2'd0,
    KIND_SYNTAX   = 2'd1,
    KIND_CAPACITY = 2'd2,
    KIND_FINISHED = 2'd3
  } result_kind_t;

  // Character classes of one text byte, worked out by the front end.
  typedef struct packed {
    logic end_mark;
    logic is_space;
    logic is_line_end;
    logic is_hash;
    logic is_quote;
    logic is_alpha;
    logic is_digit;
    logic is_label;
  } char_class_t;

  typedef struct packed {
    result_kind_t         kind;
    logic [INDEX_W-1:0]   record_index;
    logic [FIELD_W-1:0]   key_start;
    logic [FIELD_W-1:0]   key_length;
    logic [FIELD_W-1:0]   value_start;
    logic [FIELD_W-1:0]   value_length;
    logic [FIELD_W-1:0]   error_position;
    logic                 last;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/kvct_if.sv =====
// Valid/ready channel interfaces for text bytes and result tokens.
`default_nettype none

interface kvct_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       end_marker;

  modport source (output valid, byte_value, end_marker, input ready);
  modport sink (input valid, byte_value, end_marker, output ready);
endinterface

interface kvct_token_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    result_kind;
  logic [kvct_pkg::INDEX_W-1:0]  record_index;
  logic [kvct_pkg::FIELD_W-1:0]  key_start;
  logic [kvct_pkg::FIELD_W-1:0]  key_length;
  logic [kvct_pkg::FIELD_W-1:0]  value_start;
  logic [kvct_pkg::FIELD_W-1:0]  value_length;
  logic [kvct_pkg::FIELD_W-1:0]  error_position;
  logic                          last;

  modport source (output valid, result_kind, record_index, key_start, key_length,
                  value_start, value_length, error_position, last, input ready);
  modport sink (input valid, result_kind, record_index, key_start, key_length,
                value_start, value_length, error_position, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/kvct_front.sv =====
// Front end: takes text bytes and sorts each into its character classes.
`default_nettype none

module kvct_front (
  kvct_text_if.sink             text,
  output logic                  push_valid,
  input  logic                  push_ready,
  output kvct_pkg::char_class_t push_data
);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  logic [7:0] ch;
  logic       is_nul;
  logic       is_alpha;
  logic       is_digit;

  // The end of the stream is handled as a zero byte.
  assign ch = text.end_marker ? CH_NUL : text.byte_value;
  assign is_nul = (ch == CH_NUL);
  assign is_alpha = ((ch >= CH_LOWER_A) && (ch <= CH_LOWER_Z)) ||
                    ((ch >= CH_UPPER_A) && (ch <= CH_UPPER_Z));
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);

  always_comb begin
    push_data.end_mark    = text.end_marker;
    push_data.is_space    = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_LF) || is_nul;
    push_data.is_line_end = (ch == CH_LF) || is_nul;
    push_data.is_hash     = (ch == CH_HASH);
    push_data.is_quote    = (ch == CH_QUOTE);
    push_data.is_alpha    = is_alpha;
    push_data.is_digit    = is_digit;
    push_data.is_label    = is_alpha || is_digit || (ch == CH_DOT) || (ch == CH_COLON) ||
                            (ch == CH_DASH) || (ch == CH_USCORE) || (ch == CH_SLASH) ||
                            is_nul;
  end

  assign push_valid = text.valid;
  assign text.ready = push_ready;

endmodule

`default_nettype wire

// ===== rtl/kvct_queue.sv =====
// Short first-in first-out queue between the front end and the parser.
`default_nettype none

module kvct_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             push;
  logic             pop;

  assign push_ready = (fill != CNT_W'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + CNT_W'(1);
        2'b01:   fill <= fill - CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/kvct_back.sv =====
// Back end: the parser state machine and the result buffer in front of the output.
`default_nettype none

module kvct_back #(
  parameter int POSITION_BITS = 16,
  parameter int MAX_RECORDS   = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  kvct_pkg::char_class_t cmd,
  kvct_token_if.source          tokens
);

  localparam int POS_W      = POSITION_BITS;
  localparam int CNT_W      = $clog2(MAX_RECORDS + 1);
  localparam int BUF_DEPTH  = 4;
  localparam int BUF_PTR_W  = $clog2(BUF_DEPTH);
  localparam int BUF_CNT_W  = $clog2(BUF_DEPTH + 1);
  localparam logic [CNT_W-1:0] REC_LIMIT = CNT_W'(MAX_RECORDS);

  typedef enum logic [6:0] {
    PH_B4_LABEL = 7'b0000001,
    PH_IN_LABEL = 7'b0000010,
    PH_B4_VALUE = 7'b0000100,
    PH_IN_VALUE = 7'b0001000,
    PH_AF_VALUE = 7'b0010000,
    PH_IN_QUOTE = 7'b0100000,
    PH_HALT     = 7'b1000000
  } phase_t;

  phase_t           phase, phase_next;
  logic             in_comment, in_comment_next;
  logic [POS_W-1:0] position, position_next;
  logic [CNT_W-1:0] record_count, record_count_next;
  logic [POS_W-1:0] key_start, key_start_next;
  logic [POS_W-1:0] key_length, key_length_next;
  logic [POS_W-1:0] value_start, value_start_next;
  logic [POS_W-1:0] nonspace_end, nonspace_end_next;

  logic [POS_W-1:0] next_pos;
  logic [POS_W-1:0] trim_end;
  logic [POS_W-1:0] value_end;
  logic [POS_W-1:0] value_len;
  logic             proceed;
  logic             label_start;
  logic             value_begin;
  logic             emit;
  logic             step;

  kvct_pkg::result_t primary;
  kvct_pkg::result_t finish;
  logic              primary_valid;
  logic              finish_valid;
  logic [1:0]        n_push;

  kvct_pkg::result_t      res_buf [BUF_DEPTH];
  kvct_pkg::result_t      head;
  logic [BUF_PTR_W-1:0]   wr_ptr;
  logic [BUF_PTR_W-1:0]   rd_ptr;
  logic [BUF_CNT_W-1:0]   fill;
  logic                   tok_pop;

  // A byte is only taken when the buffer has room for both results it may cause.
  assign cmd_ready = (fill <= BUF_CNT_W'(BUF_DEPTH - 2));
  assign step      = cmd_valid && cmd_ready;
  assign next_pos  = position + POS_W'(1);
  assign trim_end  = (nonspace_end > value_start) ? nonspace_end : value_start;

  always_comb begin
    phase_next        = phase;
    in_comment_next   = in_comment;
    position_next     = position;
    record_count_next = record_count;
    key_start_next    = key_start;
    key_length_next   = key_length;
    value_start_next  = value_start;
    nonspace_end_next = nonspace_end;
    proceed           = 1'b0;
    label_start       = 1'b0;
    value_begin       = 1'b0;
    emit              = 1'b0;
    value_end         = value_start;
    value_len         = '0;
    primary_valid     = 1'b0;
    primary           = '0;
    finish            = '0;
    finish_valid      = 1'b0;

    if (phase != PH_HALT) begin
      if (next_pos == '1) begin
        // The position counter would reach its all-ones value.
        primary_valid          = 1'b1;
        primary.kind           = kvct_pkg::KIND_CAPACITY;
        primary.error_position = kvct_pkg::FIELD_W'(next_pos);
        phase_next             = PH_HALT;
      end else begin
        position_next = next_pos;
        proceed       = !in_comment || cmd.is_line_end;
        if (in_comment && cmd.is_line_end) begin
          in_comment_next = 1'b0;
        end
        if (proceed) begin
          unique case (phase)
            PH_B4_LABEL: begin
              label_start = !cmd.is_space;
            end
            PH_IN_LABEL: begin
              if (!cmd.is_label) begin
                key_length_next = next_pos - key_start;
                if (cmd.is_space) begin
                  phase_next = PH_B4_VALUE;
                end else begin
                  value_begin = 1'b1;
                end
              end
            end
            PH_B4_VALUE: begin
              value_begin = !cmd.is_space;
            end
            PH_IN_VALUE: begin
              if (cmd.is_hash) begin
                emit            = 1'b1;
                value_end       = trim_end;
                phase_next      = PH_B4_LABEL;
                in_comment_next = 1'b1;
              end else if (cmd.is_line_end) begin
                emit       = 1'b1;
                value_end  = trim_end;
                phase_next = PH_AF_VALUE;
              end else if (!cmd.is_space) begin
                nonspace_end_next = next_pos + POS_W'(1);
              end
            end
            PH_AF_VALUE: begin
              if (!cmd.is_space) begin
                if (cmd.is_digit) begin
                  // A digit continues the previous value line: reopen that record.
                  phase_next        = PH_IN_VALUE;
                  nonspace_end_next = next_pos + POS_W'(1);
                  if (record_count != '0) begin
                    record_count_next = record_count - CNT_W'(1);
                  end
                end else begin
                  label_start = 1'b1;
                end
              end
            end
            PH_IN_QUOTE: begin
              // A zero byte is the only line end that is also a label character.
              if (cmd.is_quote || (cmd.is_line_end && cmd.is_label)) begin
                emit       = 1'b1;
                value_end  = next_pos;
                phase_next = PH_B4_LABEL;
              end
            end
            default: begin
            end
          endcase
        end

        if (label_start) begin
          if (cmd.is_hash) begin
            phase_next      = PH_B4_LABEL;
            in_comment_next = 1'b1;
          end else if (cmd.is_alpha) begin
            phase_next     = PH_IN_LABEL;
            key_start_next = next_pos;
          end else begin
            primary_valid          = 1'b1;
            primary.kind           = kvct_pkg::KIND_SYNTAX;
            primary.error_position = kvct_pkg::FIELD_W'(next_pos);
            phase_next             = PH_HALT;
          end
        end

        if (value_begin) begin
          if (cmd.is_quote) begin
            value_start_next = next_pos + POS_W'(1);
            phase_next       = PH_IN_QUOTE;
          end else begin
            value_start_next = next_pos;
            if (cmd.is_hash) begin
              // An empty plain value cut short by a comment.
              nonspace_end_next = next_pos;
              emit              = 1'b1;
              value_end         = next_pos;
              phase_next        = PH_B4_LABEL;
              in_comment_next   = 1'b1;
            end else begin
              nonspace_end_next = next_pos + POS_W'(1);
              phase_next        = PH_IN_VALUE;
            end
          end
        end

        if (emit) begin
          primary_valid = 1'b1;
          value_len     = value_end - value_start_next;
          if (record_count >= REC_LIMIT) begin
            primary.kind           = kvct_pkg::KIND_CAPACITY;
            primary.error_position = kvct_pkg::FIELD_W'(next_pos);
            phase_next             = PH_HALT;
          end else begin
            primary.kind         = kvct_pkg::KIND_RECORD;
            primary.record_index = kvct_pkg::INDEX_W'(record_count);
            primary.key_start    = kvct_pkg::FIELD_W'(key_start);
            primary.key_length   = kvct_pkg::FIELD_W'(key_length_next);
            primary.value_start  = kvct_pkg::FIELD_W'(value_start_next);
            primary.value_length = kvct_pkg::FIELD_W'(value_len);
            record_count_next    = record_count + CNT_W'(1);
          end
        end
      end
    end

    // The end marker closes the stream and puts the parser back to its reset state.
    if (cmd.end_mark) begin
      finish_valid      = 1'b1;
      finish.kind       = kvct_pkg::KIND_FINISHED;
      finish.last       = 1'b1;
      phase_next        = PH_B4_LABEL;
      in_comment_next   = 1'b0;
      position_next     = '1;
      record_count_next = '0;
      key_start_next    = '0;
      key_length_next   = '0;
      value_start_next  = '0;
      nonspace_end_next = '0;
    end else begin
      primary.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_B4_LABEL;
      in_comment   <= 1'b0;
      position     <= '1;
      record_count <= '0;
      key_start    <= '0;
      key_length   <= '0;
      value_start  <= '0;
      nonspace_end <= '0;
    end else if (step) begin
      phase        <= phase_next;
      in_comment   <= in_comment_next;
      position     <= position_next;
      record_count <= record_count_next;
      key_start    <= key_start_next;
      key_length   <= key_length_next;
      value_start  <= value_start_next;
      nonspace_end <= nonspace_end_next;
    end
  end

  // Result buffer: up to two entries written per byte, one read per transfer.
  assign n_push  = step ? ({1'b0, primary_valid} + {1'b0, finish_valid}) : 2'd0;
  assign head    = res_buf[rd_ptr];
  assign tok_pop = tokens.valid && tokens.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + BUF_PTR_W'(n_push);
      if (tok_pop) begin
        rd_ptr <= rd_ptr + BUF_PTR_W'(1);
      end
      fill <= fill + BUF_CNT_W'(n_push) - BUF_CNT_W'(tok_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      if (primary_valid) begin
        res_buf[wr_ptr] <= primary;
      end
      if (finish_valid) begin
        res_buf[wr_ptr + BUF_PTR_W'(primary_valid)] <= finish;
      end
    end
  end

  assign tokens.valid          = (fill != '0);
  assign tokens.result_kind    = head.kind;
  assign tokens.record_index   = head.record_index;
  assign tokens.key_start      = head.key_start;
  assign tokens.key_length     = head.key_length;
  assign tokens.value_start    = head.value_start;
  assign tokens.value_length   = head.value_length;
  assign tokens.error_position = head.error_position;
  assign tokens.last           = head.last;

endmodule

`default_nettype wire

// ===== rtl/key_value_config_tokenizer.sv =====
// Top level of the key/value config tokenizer.
`default_nettype none

// Streaming tokenizer for key/value config text. One byte (or the end marker)
// is taken per cycle unless the text channel stalls: each byte is registered
// in a two-entry queue, a parser makes its whole state update as it takes
// the byte, and its results are registered in the result buffer that drives
// the token channel. A byte causes at most one result, except an end marker,
// which adds a finished result and so can need two output transfers. The
// parser takes a byte only while the four-entry result buffer has room for
// two results, so the text channel stalls when results come faster than the
// token side takes them: while the token side holds off, or when end markers
// add a finished result to another one. Reset needs no clearing pass: the
// block accepts bytes in the first cycle after reset.
module key_value_config_tokenizer #(
  parameter int POSITION_BITS = 16,
  parameter int MAX_RECORDS   = 1024
) (
  input  logic          clk,
  input  logic          rst,
  kvct_text_if.sink     text,
  kvct_token_if.source  tokens
);

  localparam int CLASS_W = $bits(kvct_pkg::char_class_t);

  logic                  push_valid;
  logic                  push_ready;
  kvct_pkg::char_class_t push_cls;
  logic                  pop_valid;
  logic                  pop_ready;
  logic [CLASS_W-1:0]    pop_data;
  kvct_pkg::char_class_t pop_cls;

  kvct_front u_front (
    .text       (text),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_cls)
  );

  kvct_queue #(
    .WIDTH (CLASS_W),
    .DEPTH (kvct_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_cls),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign pop_cls = kvct_pkg::char_class_t'(pop_data);

  kvct_back #(
    .POSITION_BITS (POSITION_BITS),
    .MAX_RECORDS   (MAX_RECORDS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (pop_valid),
    .cmd_ready (pop_ready),
    .cmd       (pop_cls),
    .tokens    (tokens)
  );

endmodule

`default_nettype wire

// ===== rtl/kvct_checker.sv =====
// Port-level checker for the tokenizer and its bind to the top level.
`default_nettype none

`include "key_value_config_tokenizer_assert.svh"

module kvct_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          text_ready,
  input logic                          tok_valid,
  input logic                          tok_ready,
  input logic [1:0]                    tok_kind,
  input logic [kvct_pkg::INDEX_W-1:0]  tok_index,
  input logic [kvct_pkg::FIELD_W-1:0]  tok_key_start,
  input logic [kvct_pkg::FIELD_W-1:0]  tok_key_length,
  input logic [kvct_pkg::FIELD_W-1:0]  tok_value_start,
  input logic [kvct_pkg::FIELD_W-1:0]  tok_value_length,
  input logic [kvct_pkg::FIELD_W-1:0]  tok_error_position,
  input logic                          tok_last
);

  // A finished result always closes the work of its byte.
  `KVCT_ASSERT(a_finish_is_last, tok_valid && (tok_kind == kvct_pkg::KIND_FINISHED), tok_last, "finished result without last")

  `KVCT_ASSERT(a_record_no_error, tok_valid && (tok_kind == kvct_pkg::KIND_RECORD), tok_error_position == '0, "record carries an error position")

  `KVCT_ASSERT(a_other_no_record, tok_valid && (tok_kind != kvct_pkg::KIND_RECORD), (tok_index == '0) && (tok_key_start == '0) && (tok_key_length == '0) && (tok_value_start == '0) && (tok_value_length == '0), "non-record result carries record fields")

  `KVCT_ASSERT(a_reset_empty, $past(rst), text_ready && !tok_valid, "block not empty after reset")

  `KVCT_ASSERT_NEXT(a_token_held, tok_valid && !tok_ready, tok_valid && $stable(tok_kind) && $stable(tok_error_position) && $stable(tok_last), "stalled token changed")

endmodule

bind key_value_config_tokenizer kvct_checker u_kvct_checker (
  .clk                (clk),
  .rst                (rst),
  .text_ready         (text.ready),
  .tok_valid          (tokens.valid),
  .tok_ready          (tokens.ready),
  .tok_kind           (tokens.result_kind),
  .tok_index          (tokens.record_index),
  .tok_key_start      (tokens.key_start),
  .tok_key_length     (tokens.key_length),
  .tok_value_start    (tokens.value_start),
  .tok_value_length   (tokens.value_length),
  .tok_error_position (tokens.error_position),
  .tok_last           (tokens.last)
);

`default_nettype wire

// ===== sim/key_value_config_tokenizer_test.sv =====
// Self-checking testbench for the key/value config tokenizer with a scoreboard class.
`timescale 1ns / 100ps

module key_value_config_tokenizer_test;

  localparam int RECORD_LIMIT = 1024;
  localparam logic [15:0] POSITION_LIMIT = 16'hFFFF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int LONG_STALL = 400;
  localparam int RANDOM_BYTES = 760;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;

  typedef enum logic [2:0] {
    SEEK_KEY, IN_KEY, SEEK_VALUE, IN_PLAIN, AFTER_LINE, IN_QUOTED, HALTED
  } parse_phase_t;

  class token_scoreboard;
    kvct_pkg::result_t pending_tokens[$];
    kvct_pkg::result_t step_tokens[$];
    int           errors;
    int           checked;
    parse_phase_t phase;
    bit           in_comment;
    logic [15:0]  position;
    int unsigned  records;
    logic [15:0]  key_start;
    logic [15:0]  key_length;
    logic [15:0]  value_start;
    logic [15:0]  plain_end;

    function new();
      errors = 0;
      checked = 0;
      restart();
    endfunction

    function void restart();
      phase = SEEK_KEY;
      in_comment = 1'b0;
      position = '1;
      records = 0;
      key_start = '0;
      key_length = '0;
      value_start = '0;
      plain_end = '0;
    endfunction

    function bit is_space(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_NUL;
    endfunction

    function bit is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit is_key_char(logic [7:0] c);
      return is_alpha(c) || is_digit(c) || c == "." || c == ":" || c == "-" ||
             c == "_" || c == "/" || c == CH_NUL;
    endfunction

    function void add_token(kvct_pkg::result_kind_t kind, logic [9:0] index,
                            logic [15:0] ks, logic [15:0] kl, logic [15:0] vs,
                            logic [15:0] vl, logic [15:0] ep);
      kvct_pkg::result_t r;
      if (step_tokens.size() >= 2) return;
      r.kind = kind;
      r.record_index = index;
      r.key_start = ks;
      r.key_length = kl;
      r.value_start = vs;
      r.value_length = vl;
      r.error_position = ep;
      r.last = 1'b0;
      step_tokens.push_back(r);
    endfunction

    function void close_record(logic [15:0] value_length);
      if (records >= RECORD_LIMIT) begin
        add_token(kvct_pkg::KIND_CAPACITY, '0, '0, '0, '0, '0, position);
        phase = HALTED;
        return;
      end
      add_token(kvct_pkg::KIND_RECORD, 10'(records), key_start, key_length, value_start,
                value_length, '0);
      records++;
    endfunction

    // One pass of the parser over the current byte; a set return means the
    // byte has to be looked at again in the new phase.
    function bit parse_char(logic [7:0] ch);
      logic [15:0] trimmed_end;
      bit again;
      again = 1'b0;
      if (in_comment) begin
        if (ch == CH_LF || ch == CH_NUL) in_comment = 1'b0;
        else return 1'b0;
      end
      if ((phase == SEEK_KEY || phase == SEEK_VALUE || phase == AFTER_LINE) &&
          is_space(ch)) return 1'b0;
      case (phase)
        SEEK_KEY: begin
          if (ch == CH_HASH) begin
            in_comment = 1'b1;
            again = 1'b1;
          end else if (is_alpha(ch)) begin
            phase = IN_KEY;
            key_start = position;
            again = 1'b1;
          end else begin
            add_token(kvct_pkg::KIND_SYNTAX, '0, '0, '0, '0, '0, position);
            phase = HALTED;
          end
        end
        IN_KEY: begin
          if (!is_key_char(ch)) begin
            key_length = position - key_start;
            phase = SEEK_VALUE;
            again = 1'b1;
          end
        end
        SEEK_VALUE: begin
          if (ch == CH_QUOTE) begin
            value_start = position + 16'd1;
            phase = IN_QUOTED;
          end else begin
            value_start = position;
            plain_end = position;
            phase = IN_PLAIN;
            again = 1'b1;
          end
        end
        IN_PLAIN: begin
          if (ch == CH_HASH || ch == CH_LF || ch == CH_NUL) begin
            trimmed_end = (plain_end < value_start) ? value_start : plain_end;
            if (ch == CH_HASH) begin
              phase = SEEK_KEY;
              in_comment = 1'b1;
              again = 1'b1;
            end else begin
              phase = AFTER_LINE;
            end
            close_record(trimmed_end - value_start);
          end else if (!is_space(ch)) begin
            plain_end = position + 16'd1;
          end
        end
        AFTER_LINE: begin
          // A digit here continues the previous value under the same index.
          if (is_digit(ch)) begin
            phase = IN_PLAIN;
            if (records > 0) records--;
          end else begin
            phase = SEEK_KEY;
          end
          again = 1'b1;
        end
        IN_QUOTED: begin
          if (ch == CH_QUOTE || ch == CH_NUL) begin
            phase = SEEK_KEY;
            close_record(position - value_start);
          end
        end
        default: ;
      endcase
      if (phase == HALTED) again = 1'b0;
      return again;
    endfunction

    function void tokenize_byte(logic [7:0] value, logic stop);
      logic [7:0] ch;
      int pass;
      ch = stop ? CH_NUL : value;
      step_tokens.delete();
      if (phase != HALTED) begin
        if (position + 16'd1 == POSITION_LIMIT) begin
          add_token(kvct_pkg::KIND_CAPACITY, '0, '0, '0, '0, '0, POSITION_LIMIT);
          phase = HALTED;
        end else begin
          position = position + 16'd1;
          for (pass = 0; pass < 8; pass++)
            if (!parse_char(ch)) break;
        end
      end
      if (stop) begin
        add_token(kvct_pkg::KIND_FINISHED, '0, '0, '0, '0, '0, '0);
        restart();
      end
      if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
      foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
    endfunction

    function void note_text_byte(logic [7:0] value, logic stop);
      tokenize_byte(value, stop);
    endfunction

    task report(string what);
      if (errors < 50) $display("mismatch: %s", what);
      errors++;
    endtask

    task check_token(kvct_pkg::result_t got);
      kvct_pkg::result_t want;
      string diffs;
      checked++;
      if (pending_tokens.size() == 0) begin
        report($sformatf("token %0d of kind %0d arrived with none expected",
                         checked, got.kind));
        return;
      end
      want = pending_tokens.pop_front();
      diffs = "";
      if (got.kind !== want.kind) diffs = {diffs, " kind"};
      if (got.record_index !== want.record_index) diffs = {diffs, " record_index"};
      if (got.key_start !== want.key_start) diffs = {diffs, " key_start"};
      if (got.key_length !== want.key_length) diffs = {diffs, " key_length"};
      if (got.value_start !== want.value_start) diffs = {diffs, " value_start"};
      if (got.value_length !== want.value_length) diffs = {diffs, " value_length"};
      if (got.error_position !== want.error_position) diffs = {diffs, " error_position"};
      if (got.last !== want.last) diffs = {diffs, " last"};
      if (diffs != "")
        report($sformatf("token %0d differs in%s: got %h want %h", checked, diffs,
                         got, want));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  kvct_text_if text_ch();
  kvct_token_if token_ch();

  key_value_config_tokenizer dut (
    .clk(clk),
    .rst(rst),
    .text(text_ch),
    .tokens(token_ch)
  );

  token_scoreboard sb;
  bit steady = 1'b0;
  int bytes_sent = 0;
  int stall_left = 0;
  int long_stall_mark = 30;
  int quiet_cycles = 0;
  bit moved;
  kvct_pkg::result_t seen;

  always #5 clk = ~clk;

  // Transfers on both channels are picked up here, input first.
  always @(posedge clk) begin
    if (!rst) begin
      moved = 1'b0;
      if (text_ch.valid && text_ch.ready) begin
        sb.note_text_byte(text_ch.byte_value, text_ch.end_marker);
        moved = 1'b1;
      end
      if (token_ch.valid && token_ch.ready) begin
        seen.kind = kvct_pkg::result_kind_t'(token_ch.result_kind);
        seen.record_index = token_ch.record_index;
        seen.key_start = token_ch.key_start;
        seen.key_length = token_ch.key_length;
        seen.value_start = token_ch.value_start;
        seen.value_length = token_ch.value_length;
        seen.error_position = token_ch.error_position;
        seen.last = token_ch.last;
        sb.check_token(seen);
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Token side: random stalls, plus a long hold-off now and then so that the
  // result buffer fills and the text channel backs up.
  initial begin
    token_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        token_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        token_ch.ready <= 1'b0;
        stall_left--;
      end else if (sb.checked >= long_stall_mark) begin
        stall_left = LONG_STALL;
        long_stall_mark += 700;
        token_ch.ready <= 1'b0;
      end else begin
        token_ch.ready <= steady || ($urandom_range(99) >= 9);
      end
    end
  end

  function automatic logic [7:0] rand_letter();
    logic [7:0] base;
    base = $urandom_range(1) ? "a" : "A";
    return base + 8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_key_char();
    string marks;
    int pick;
    marks = ".:-_/";
    pick = $urandom_range(15);
    if (pick == 0) return CH_NUL;
    if (pick < 4) return marks[$urandom_range(4)];
    if (pick < 8) return "0" + 8'($urandom_range(9));
    return rand_letter();
  endfunction

  // Any nonzero byte other than the two given.
  function automatic logic [7:0] rand_byte_but(logic [7:0] a, logic [7:0] b);
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == a || c == b);
    return c;
  endfunction

  function automatic logic [7:0] rand_blank();
    int pick;
    pick = $urandom_range(2);
    return (pick == 0) ? CH_SPACE : (pick == 1) ? CH_TAB : CH_LF;
  endfunction

  task automatic send_byte(input logic [7:0] value, input logic stop = 1'b0);
    if (!steady && $urandom_range(99) < 6) begin
      text_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    text_ch.valid <= 1'b1;
    text_ch.byte_value <= value;
    text_ch.end_marker <= stop;
    do @(posedge clk); while (!text_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic finish_stream();
    send_byte(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic drain();
    text_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending_tokens.size() != 0);
  endtask

  task automatic send_record();
    send_byte(rand_letter());
    repeat ($urandom_range(0, 4)) send_byte(rand_key_char());
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(0, 1)) send_byte(CH_SPACE);
      send_byte(CH_QUOTE);
      repeat ($urandom_range(0, 6)) send_byte(rand_byte_but(CH_QUOTE, CH_QUOTE));
      send_byte(CH_QUOTE);
    end else begin
      repeat ($urandom_range(1, 2)) send_byte(rand_blank());
      repeat ($urandom_range(0, 6)) send_byte(rand_byte_but(CH_LF, CH_HASH));
      repeat ($urandom_range(0, 2)) send_byte(CH_SPACE);
      if ($urandom_range(4) == 0) begin
        send_byte(CH_HASH);
        repeat ($urandom_range(0, 3)) send_byte(rand_byte_but(CH_LF, CH_LF));
      end
      send_byte(CH_LF);
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(0, 2)) send_byte(CH_SPACE);
        send_byte("0" + 8'($urandom_range(9)));
        repeat ($urandom_range(0, 3)) send_byte(rand_byte_but(CH_LF, CH_HASH));
        send_byte(CH_LF);
      end
    end
  endtask

  task automatic random_stream();
    int pick;
    repeat ($urandom_range(1, 10)) begin
      pick = $urandom_range(39);
      if (pick < 30) begin
        send_record();
      end else if (pick < 34) begin
        send_byte(CH_HASH);
        repeat ($urandom_range(0, 5)) send_byte(rand_byte_but(CH_LF, CH_LF));
        send_byte(CH_LF);
      end else if (pick < 37) begin
        send_byte(rand_blank());
      end else if (pick == 37) begin
        send_byte(8'($urandom_range(255)));
      end else if (pick == 38) begin
        send_byte(CH_NUL);
      end else begin
        // A quote left open; whatever follows, up to a quote or zero byte, becomes its content.
        send_byte(rand_letter());
        send_byte(CH_QUOTE);
        repeat ($urandom_range(0, 4)) send_byte(rand_byte_but(CH_QUOTE, CH_QUOTE));
      end
    end
    finish_stream();
  endtask

  initial begin
    int goal;
    int mark;
    sb = new();
    rst <= 1'b1;
    text_ch.valid <= 1'b0;
    text_ch.byte_value <= '0;
    text_ch.end_marker <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // A zero byte inside a key, then a continuation line that resends it.
    send_text("k");
    send_byte(CH_NUL);
    send_text(" v\n");
    send_text("7\t#c\n");
    send_text("q \"x\ny\"");
    // A zero byte closes a quoted value.
    send_text("w \"a");
    send_byte(CH_NUL);
    send_text("\n");
    // Newline before the value, then the end drops the record.
    send_text("z\n");
    finish_stream();
    // End inside a key drops the record as well.
    send_text("ab");
    finish_stream();
    // Bad first character halts the parser until the end marker.
    send_byte(8'hFF);
    send_byte(CH_NUL);
    finish_stream();
    drain();

    mark = bytes_sent;
    goal = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < goal) begin
      steady = (bytes_sent - mark >= 300) && (bytes_sent - mark < 450);
      random_stream();
      if ($urandom_range(9) == 0) drain();
    end
    steady = 1'b0;

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
